FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers used by the cipher unit: clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define KXS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define KXS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/kxs_pkg.sv
// ----------------------------------------------------------------------------
// kxs_pkg
// Shared constants, state codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package kxs_pkg;

  // Key store sizing
  localparam int KEY_MAX = 64;
  localparam int KEY_AW  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int KEY_LW  = $clog2(KEY_MAX + 1);

  // Mixing rounds
  localparam int MIX_ROUNDS = 16;
  localparam int RND_W      = $clog2(MIX_ROUNDS + 1);

  // Keystream and scratch sizing
  localparam int KS_DEPTH = 256;
  localparam int KS_AW    = 8;
  localparam int CNT_W    = KS_AW + 1;

  // Schedule and advance coefficients
  localparam logic [7:0] FILL_MUL   = 8'd17;
  localparam logic [7:0] FILL_ADD   = 8'd3;
  localparam logic [7:0] GATHER_MUL = 8'd31;
  localparam logic [7:0] ROUND_MUL  = 8'd7;
  localparam logic [7:0] WB_MUL     = 8'd13;
  localparam logic [7:0] ADV_MUL    = 8'd31;
  localparam logic [7:0] ADV_ADD    = 8'd7;

  // Input word kinds
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_GATHER,
    S_WBACK,
    S_DOUT,
    S_ADV
  } state_t;

  typedef enum logic [2:0] {
    PASS_NONE,
    PASS_FILL,
    PASS_GATHER,
    PASS_WBACK,
    PASS_ADV
  } pass_t;

  typedef struct packed {
    logic  accept_key;
    logic  accept_data;
    logic  load_out;
    logic  pass_start;
    logic  round_clr;
    logic  round_inc;
    logic  sched_done;
    pass_t mode;
  } cmd_t;

  typedef struct packed {
    logic pass_done;
    logic round_last;
    logic adv_needed;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/kxs_dpath.sv
// ----------------------------------------------------------------------------
// kxs_dpath
// Key store, keystream and scratch memories, pass pipeline, stream position
// and output register of the cipher unit.
// ----------------------------------------------------------------------------
module kxs_dpath (
  input  logic                  clk,
  input  logic                  rst,
  input  kxs_pkg::cmd_t         cmd,
  output kxs_pkg::status_t      stat,
  input  logic [7:0]            value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  no_key
);

  // Memories
  logic [7:0] key_mem [kxs_pkg::KEY_MAX];
  logic [7:0] ks_mem  [kxs_pkg::KS_DEPTH];
  logic [7:0] scr_mem [kxs_pkg::KS_DEPTH];

  // Key load state
  logic [kxs_pkg::KEY_LW-1:0] key_length;
  logic [kxs_pkg::KEY_LW-1:0] eff_len;
  logic                       loading;
  logic [kxs_pkg::KEY_AW-1:0] kidx;
  logic [7:0]                 key_rd;

  // Pass pipeline
  logic [kxs_pkg::CNT_W-1:0] cnt;
  logic                      issue;
  logic [7:0]                i0;
  logic                      v1;
  logic                      v2;
  logic [7:0]                i1;
  logic [7:0]                i2;
  logic [kxs_pkg::RND_W-1:0] rnd;
  logic [7:0]                rnd8;
  logic [7:0]                rofs;

  // Memory ports
  logic [7:0] ks_ra;
  logic [7:0] ks_rb;
  logic [7:0] ks_qa;
  logic [7:0] ks_qb;
  logic       ks_we;
  logic [7:0] ks_wd;
  logic [7:0] scr_q;
  logic       scr_we;

  // Stream state
  logic [7:0] pos;
  logic       past;
  logic       keyed;
  logic [7:0] data_hold;

  assign i0    = cnt[7:0];
  assign issue = (cmd.mode != kxs_pkg::PASS_NONE) &&
                 (cnt < kxs_pkg::CNT_W'(kxs_pkg::KS_DEPTH));
  assign rnd8  = 8'(rnd);
  assign rofs  = 8'(rnd8 * kxs_pkg::ROUND_MUL);

  // Step the pass counter and pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= kxs_pkg::CNT_W'(kxs_pkg::KS_DEPTH);
      v1  <= 1'b0;
      v2  <= 1'b0;
    end else begin
      if (cmd.pass_start) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + kxs_pkg::CNT_W'(1);
      end
      v1 <= issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    i1 <= i0;
    i2 <= i1;
  end

  // Count mixing rounds
  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= '0;
    end else if (cmd.round_clr) begin
      rnd <= '0;
    end else if (cmd.round_inc) begin
      rnd <= rnd + kxs_pkg::RND_W'(1);
    end
  end

  // Track key length; a key word outside a load starts a new key
  assign eff_len = loading ? key_length : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= '0;
      loading    <= 1'b0;
    end else begin
      if (cmd.accept_key) begin
        loading <= 1'b1;
        if (eff_len < kxs_pkg::KEY_LW'(kxs_pkg::KEY_MAX)) begin
          key_length <= eff_len + kxs_pkg::KEY_LW'(1);
        end else begin
          key_length <= eff_len;
        end
      end else if (cmd.sched_done) begin
        loading <= 1'b0;
      end
    end
  end

  // Store key words, drop those beyond capacity
  always_ff @(posedge clk) begin
    if (cmd.accept_key && (eff_len < kxs_pkg::KEY_LW'(kxs_pkg::KEY_MAX))) begin
      key_mem[eff_len[kxs_pkg::KEY_AW-1:0]] <= value;
    end
    key_rd <= key_mem[kidx];
  end

  // Cycle the key index modulo the key length during the fill pass
  always_ff @(posedge clk) begin
    if (cmd.pass_start) begin
      kidx <= '0;
    end else if (issue && (cmd.mode == kxs_pkg::PASS_FILL)) begin
      if ((kxs_pkg::KEY_LW'(kidx) + kxs_pkg::KEY_LW'(1)) >= key_length) begin
        kidx <= '0;
      end else begin
        kidx <= kidx + kxs_pkg::KEY_AW'(1);
      end
    end
  end

  // Select keystream read addresses
  always_comb begin
    case (cmd.mode)
      kxs_pkg::PASS_GATHER: ks_ra = 8'(i0 + 8'd1);
      kxs_pkg::PASS_ADV:    ks_ra = i0;
      default:              ks_ra = pos;
    endcase
  end

  assign ks_rb = 8'(8'(i1 * kxs_pkg::GATHER_MUL) + rofs + ks_qa);

  // Select keystream write data
  always_comb begin
    ks_we = 1'b0;
    ks_wd = '0;
    case (cmd.mode)
      kxs_pkg::PASS_FILL: begin
        ks_we = v1;
        ks_wd = key_rd ^ 8'(8'(i1 * kxs_pkg::FILL_MUL) + kxs_pkg::FILL_ADD);
      end
      kxs_pkg::PASS_WBACK: begin
        ks_we = v1;
        ks_wd = scr_q ^ 8'(8'(i1 * kxs_pkg::WB_MUL) + rnd8);
      end
      kxs_pkg::PASS_ADV: begin
        ks_we = v1;
        ks_wd = 8'(8'(ks_qa * kxs_pkg::ADV_MUL) + i1 + kxs_pkg::ADV_ADD);
      end
      default: begin
        ks_we = 1'b0;
        ks_wd = '0;
      end
    endcase
  end

  assign scr_we = v2 && (cmd.mode == kxs_pkg::PASS_GATHER);

  // Keystream: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (ks_we) begin
      ks_mem[i1] <= ks_wd;
    end
    ks_qa <= ks_mem[ks_ra];
    ks_qb <= ks_mem[ks_rb];
  end

  // Scratch: gathered entries, read back in index order
  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mem[i2] <= ks_qb;
    end
    scr_q <= scr_mem[i0];
  end

  // Hold the data word until its result loads
  always_ff @(posedge clk) begin
    if (cmd.accept_data) begin
      data_hold <= value;
    end
  end

  // Advance stream position; restart it when a schedule completes
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      past  <= 1'b0;
      keyed <= 1'b0;
    end else if (cmd.sched_done) begin
      pos   <= '0;
      past  <= 1'b0;
      keyed <= 1'b1;
    end else if (cmd.load_out && keyed) begin
      pos  <= pos + 8'd1;
      past <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_byte <= keyed ? (data_hold ^ ks_qa) : data_hold;
      no_key   <= !keyed;
    end
  end

  // Status back to the controller
  assign stat.pass_done  = (cnt == kxs_pkg::CNT_W'(kxs_pkg::KS_DEPTH)) && !v1 && !v2;
  assign stat.round_last = (rnd == kxs_pkg::RND_W'(kxs_pkg::MIX_ROUNDS - 1));
  assign stat.adv_needed = keyed && past && (pos == 8'd0);
  assign stat.out_free   = !out_valid || out_ready;

endmodule

FILE: rtl/kxs_ctrl.sv
// ----------------------------------------------------------------------------
// kxs_ctrl
// Controller of the cipher unit: word intake, key schedule passes, result
// hand-off and the keystream advance pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kxs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              op,
  input  logic              last,
  input  kxs_pkg::status_t  stat,
  output kxs_pkg::cmd_t     cmd
);

  kxs_pkg::state_t state;
  kxs_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kxs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      kxs_pkg::S_IDLE: begin
        if (in_valid) begin
          if (op == kxs_pkg::OP_DATA) begin
            state_next = kxs_pkg::S_DOUT;
          end else if (last) begin
            state_next = kxs_pkg::S_FILL;
          end
        end
      end
      kxs_pkg::S_FILL: begin
        if (stat.pass_done) state_next = kxs_pkg::S_GATHER;
      end
      kxs_pkg::S_GATHER: begin
        if (stat.pass_done) state_next = kxs_pkg::S_WBACK;
      end
      kxs_pkg::S_WBACK: begin
        if (stat.pass_done) begin
          state_next = stat.round_last ? kxs_pkg::S_IDLE : kxs_pkg::S_GATHER;
        end
      end
      kxs_pkg::S_DOUT: begin
        if (stat.out_free) begin
          state_next = stat.adv_needed ? kxs_pkg::S_ADV : kxs_pkg::S_IDLE;
        end
      end
      kxs_pkg::S_ADV: begin
        if (stat.pass_done) state_next = kxs_pkg::S_IDLE;
      end
      default: state_next = kxs_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    in_ready = 1'b0;
    cmd      = '{accept_key: 1'b0, accept_data: 1'b0, load_out: 1'b0,
                 pass_start: 1'b0, round_clr: 1'b0, round_inc: 1'b0,
                 sched_done: 1'b0, mode: kxs_pkg::PASS_NONE};
    case (state)
      kxs_pkg::S_IDLE: begin
        in_ready        = 1'b1;
        cmd.accept_key  = in_valid && (op == kxs_pkg::OP_KEY);
        cmd.accept_data = in_valid && (op == kxs_pkg::OP_DATA);
        cmd.pass_start  = cmd.accept_key && last;
        cmd.round_clr   = cmd.accept_key && last;
      end
      kxs_pkg::S_FILL: begin
        cmd.mode       = kxs_pkg::PASS_FILL;
        cmd.pass_start = stat.pass_done;
      end
      kxs_pkg::S_GATHER: begin
        cmd.mode       = kxs_pkg::PASS_GATHER;
        cmd.pass_start = stat.pass_done;
      end
      kxs_pkg::S_WBACK: begin
        cmd.mode       = kxs_pkg::PASS_WBACK;
        cmd.sched_done = stat.pass_done && stat.round_last;
        cmd.pass_start = stat.pass_done && !stat.round_last;
        cmd.round_inc  = stat.pass_done && !stat.round_last;
      end
      kxs_pkg::S_DOUT: begin
        cmd.load_out   = stat.out_free;
        cmd.pass_start = stat.out_free && stat.adv_needed;
      end
      kxs_pkg::S_ADV: begin
        cmd.mode = kxs_pkg::PASS_ADV;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Schedule ends only after the final round's write-back drains
  `KXS_ASSERT(a_sched_done_last, cmd.sched_done |-> (stat.round_last && stat.pass_done), "schedule ended early")
  // Fill pass hands over to the first gather pass
  `KXS_ASSERT_NEXT(a_fill_to_gather, (state == kxs_pkg::S_FILL) && stat.pass_done, state == kxs_pkg::S_GATHER, "fill pass did not start mixing")
  // A result waits while the output register is occupied
  `KXS_ASSERT_NEXT(a_dout_waits, (state == kxs_pkg::S_DOUT) && !stat.out_free, (state == kxs_pkg::S_DOUT) && !in_ready, "result dropped on stall")

endmodule

FILE: rtl/keyed_xor_stream_cipher_unit.sv
// ----------------------------------------------------------------------------
// keyed_xor_stream_cipher_unit
// Byte stream cipher with a loadable key and a 256-entry keystream.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid/in_ready) carry op, value and last. A key word
//   (op = 0) is taken only while idle; the key word marked last starts
//   the schedule: a fill pass plus MIX_ROUNDS gather and write-back passes
//   over the keystream. No word is taken during the schedule.
//   A data word (op = 1) produces one result word (out_valid/out_ready)
//   with out_byte and no_key. It takes two steps: accept, then load of the
//   output register from the keystream read port. After each byte at a
//   nonzero multiple of 256 in the stream, an advance pass over the
//   keystream runs before the next word is taken.
//   If the receiver stalls, the result holds in the output register; the
//   next word is still accepted, and its result waits until the register
//   frees. Before any key, data passes unchanged with no_key set.
//   Reset (rst, synchronous) clears the key, the stream position and the
//   output valid; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module keyed_xor_stream_cipher_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic [7:0] value,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       no_key
);

  kxs_pkg::cmd_t    cmd;
  kxs_pkg::status_t stat;

  // Controller
  kxs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .last     (last),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath
  kxs_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .no_key    (no_key)
  );

endmodule
